### hw/rtl/isotp_rr_pkg.sv
package isotp_rr_pkg;

    // Default depth of the payload store
    localparam int PAYLOAD_BYTES_DEF = 16;

    // Input item types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_FLOW   = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_REQUEST_ID  = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_ID = 2'd1;
    localparam logic [1:0] CFG_DATA_ID     = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

    // Configuration reset values
    localparam logic [10:0] REQUEST_ID_RST  = 11'h703;
    localparam logic [10:0] RESPONSE_ID_RST = 11'h70B;
    localparam logic [15:0] DATA_ID_RST     = 16'hFDBD;
    localparam logic [15:0] TIMEOUT_RST     = 16'd2000;

    // Frame type nibbles of the protocol control byte
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    localparam logic [7:0] SID_POSITIVE  = 8'h62;
    localparam logic [7:0] MIN_TOTAL_LEN = 8'd3;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [10:0] request_id;
        logic [10:0] response_id;
        logic [15:0] data_identifier;
        logic [15:0] limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [10:0]     can_id;
        logic [7:0][7:0] data;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [1:0] status;
        logic       last;
    } result_t;

endpackage

### hw/rtl/isotp_rr_store.sv
module isotp_rr_store
    import isotp_rr_pkg::*;
#(
    parameter int DEPTH = PAYLOAD_BYTES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/isotp_rr_ctrl.sv
module isotp_rr_ctrl
    import isotp_rr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1,
    localparam int CW = $clog2(PAYLOAD_BYTES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  item_t         item,
    input  logic          start,
    output logic          busy,
    input  logic          out_free,
    output logic          push,
    output result_t       push_res,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_STORE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT
    } state_t;

    localparam logic [7:0]    DEPTH_B = 8'(PAYLOAD_BYTES);
    localparam logic [CW-1:0] DEPTH_C = CW'(PAYLOAD_BYTES);

    state_t        state_reg, state_next;
    logic          armed_reg, armed_next;
    logic          receiving_reg, receiving_next;
    logic [3:0]    exp_seq_reg, exp_seq_next;
    logic [7:0]    total_len_reg, total_len_next;
    logic [7:0]    byte_count_reg, byte_count_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic [2:0]    idx_reg, idx_next;
    logic          ff_mode_reg, ff_mode_next;
    logic [CW-1:0] scan_reg, scan_next;
    result_t       pend_reg, pend_next;

    logic [7:0]  need;
    logic        can_store;
    logic [7:0]  bc_inc;
    logic [7:0]  bc_after;
    logic        scan_more;
    logic [15:0] elapsed_inc;
    logic [3:0]  pci;
    logic [3:0]  seq;
    logic        id_ok;
    logic        di_ok;

    // Shared datapath terms
    assign need        = total_len_reg - MIN_TOTAL_LEN;
    assign can_store   = ff_mode_reg || (byte_count_reg < need);
    assign bc_inc      = byte_count_reg + 8'd1;
    assign bc_after    = can_store ? bc_inc : byte_count_reg;
    assign scan_more   = (scan_reg < DEPTH_C) && (8'(scan_reg) < byte_count_reg);
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign pci         = item.data[0][7:4];
    assign seq         = item.data[0][3:0];
    assign id_ok       = (item.can_id != cfg.request_id) && (item.can_id == cfg.response_id);
    assign di_ok       = (item.data[2] == SID_POSITIVE)
                      && (item.data[3] == cfg.data_identifier[15:8])
                      && (item.data[4] == cfg.data_identifier[7:0]);

    // Payload store ports
    assign wr_en   = (state_reg == S_STORE) && can_store && (byte_count_reg < DEPTH_B);
    assign wr_addr = byte_count_reg[AW-1:0];
    assign wr_data = item.data[idx_reg];
    assign rd_en   = (state_reg == S_SCAN_RD) && scan_more;
    assign rd_addr = scan_reg[AW-1:0];

    assign busy = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        receiving_next  = receiving_reg;
        exp_seq_next    = exp_seq_reg;
        total_len_next  = total_len_reg;
        byte_count_next = byte_count_reg;
        elapsed_next    = elapsed_reg;
        idx_next        = idx_reg;
        ff_mode_next    = ff_mode_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_res        = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                pend_next  = '{kind: KIND_STATUS, char_value: 8'd0,
                               status: ST_INVALID, last: 1'b1};
                if (item.req_type == REQ_START)
                begin
                    armed_next      = 1'b1;
                    receiving_next  = 1'b0;
                    exp_seq_next    = 4'd1;
                    total_len_next  = 8'd0;
                    byte_count_next = 8'd0;
                    elapsed_next    = 16'd0;
                end
                else if (armed_reg)
                begin
                    case (item.req_type)
                        REQ_TICK:
                        begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc >= cfg.limit_ms)
                            begin
                                pend_next.status = ST_TIMEOUT;
                                armed_next       = 1'b0;
                                receiving_next   = 1'b0;
                                state_next       = S_EMIT;
                            end
                        end

                        REQ_FRAME:
                        begin
                            if (id_ok)
                            begin
                                if (pci == PCI_FIRST)
                                begin
                                    // Ignore a repeated first frame
                                    if (!receiving_reg)
                                    begin
                                        total_len_next  = item.data[1];
                                        exp_seq_next    = 4'd1;
                                        byte_count_next = 8'd0;
                                        if (!di_ok || (item.data[1] < MIN_TOTAL_LEN))
                                        begin
                                            armed_next = 1'b0;
                                            state_next = S_EMIT;
                                        end
                                        else
                                        begin
                                            receiving_next = 1'b1;
                                            idx_next       = 3'd5;
                                            ff_mode_next   = 1'b1;
                                            state_next     = S_STORE;
                                        end
                                    end
                                end
                                else if (pci == PCI_CONSEC)
                                begin
                                    if (!receiving_reg || (seq > exp_seq_reg))
                                    begin
                                        armed_next     = 1'b0;
                                        receiving_next = 1'b0;
                                        state_next     = S_EMIT;
                                    end
                                    else if (seq == exp_seq_reg)
                                    begin
                                        idx_next     = 3'd1;
                                        ff_mode_next = 1'b0;
                                        state_next   = S_STORE;
                                    end
                                end
                                else
                                begin
                                    armed_next     = 1'b0;
                                    receiving_next = 1'b0;
                                    state_next     = S_EMIT;
                                end
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            // Store one frame byte per cycle
            S_STORE:
            begin
                byte_count_next = bc_after;
                if (!can_store || (idx_reg == 3'd7))
                begin
                    if (ff_mode_reg)
                    begin
                        pend_next  = '{kind: KIND_FLOW, char_value: 8'd0,
                                       status: ST_OK, last: 1'b1};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        exp_seq_next = exp_seq_reg + 4'd1;
                        if (bc_after >= need)
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end

            // Read the next stored byte or close with success
            S_SCAN_RD:
            begin
                if (scan_more)
                begin
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    pend_next      = '{kind: KIND_STATUS, char_value: 8'd0,
                                       status: ST_OK, last: 1'b1};
                    armed_next     = 1'b0;
                    receiving_next = 1'b0;
                    state_next     = S_EMIT;
                end
            end

            // Drop zero bytes, emit the rest
            S_SCAN_CHK:
            begin
                push_res = '{kind: KIND_CHAR, char_value: rd_data,
                             status: ST_OK, last: 1'b0};
                if (rd_data == 8'd0)
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
                else if (out_free)
                begin
                    push       = 1'b1;
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            armed_reg      <= 1'b0;
            receiving_reg  <= 1'b0;
            exp_seq_reg    <= 4'd1;
            total_len_reg  <= 8'd0;
            byte_count_reg <= 8'd0;
            elapsed_reg    <= 16'd0;
            idx_reg        <= 3'd0;
            ff_mode_reg    <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            receiving_reg  <= receiving_next;
            exp_seq_reg    <= exp_seq_next;
            total_len_reg  <= total_len_next;
            byte_count_reg <= byte_count_next;
            elapsed_reg    <= elapsed_next;
            idx_reg        <= idx_next;
            ff_mode_reg    <= ff_mode_next;
            scan_reg       <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into an occupied output register");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (byte_count_reg < DEPTH_B))
        else $error("payload write beyond store depth");

    a_receiving_armed: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> armed_reg)
        else $error("receiving while disarmed");

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_res.kind == KIND_CHAR)) |-> (push_res.char_value != 8'd0))
        else $error("zero payload byte emitted");

    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_res.kind == KIND_STATUS)) |=> !armed_reg)
        else $error("still armed after final status");

endmodule

### hw/rtl/isotp_read_response_reassembler.sv
// Receive side of a multi-frame diagnostic read response. A start item arms the block;
// frames whose identifier is the response identifier (and not the request identifier)
// are parsed as first and consecutive frames, and millisecond ticks run the timeout.
// Each item is taken into a register and worked on by a small sequencer, and in_stall
// stays high until it is done. A start, tick, dropped or ignored frame is only decoded;
// a tick that times out or a rejected frame adds a status beat. A first frame stores
// its payload bytes from position 5 and adds a flow-control beat; a consecutive frame
// stores bytes from position 1, visiting one byte position per step until it has stored
// the bytes still needed or reached position 7. A completing frame then reads the
// payload store one entry at a time over its single read port, with a read state and a
// check state for each of the first min(byte count, PAYLOAD_BYTES) entries, then sends
// the status beat, waiting whenever the output side stalls. One finished beat waits in
// the output register while the next input item is taken.
module isotp_read_response_reassembler
    import isotp_rr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [10:0] can_id,
    input  logic [7:0]  data_0,
    input  logic [7:0]  data_1,
    input  logic [7:0]  data_2,
    input  logic [7:0]  data_3,
    input  logic [7:0]  data_4,
    input  logic [7:0]  data_5,
    input  logic [7:0]  data_6,
    input  logic [7:0]  data_7,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  char_value,
    output logic [1:0]  status,
    output logic        last
);

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    cfg_t    cfg_reg;
    item_t   item_reg;
    result_t out_reg;
    logic    out_valid_reg;

    logic          busy;
    logic          in_accept;
    logic          out_free;
    logic          push;
    result_t       push_res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.request_id      <= REQUEST_ID_RST;
            cfg_reg.response_id     <= RESPONSE_ID_RST;
            cfg_reg.data_identifier <= DATA_ID_RST;
            cfg_reg.limit_ms        <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REQUEST_ID:  cfg_reg.request_id      <= cfg_data[10:0];
                CFG_RESPONSE_ID: cfg_reg.response_id     <= cfg_data[10:0];
                CFG_DATA_ID:     cfg_reg.data_identifier <= cfg_data;
                CFG_TIMEOUT:     cfg_reg.limit_ms        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.req_type <= req_type;
            item_reg.can_id   <= can_id;
            item_reg.data     <= {data_7, data_6, data_5, data_4,
                                  data_3, data_2, data_1, data_0};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign char_value = out_reg.char_value;
    assign status     = out_reg.status;
    assign last       = out_reg.last;

    isotp_rr_ctrl #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .item     (item_reg),
        .start    (in_accept),
        .busy     (busy),
        .out_free (out_free),
        .push     (push),
        .push_res (push_res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    isotp_rr_store #(
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
